// ===== rtl/fsir_pkg.sv =====
// Shared widths, table entry layout and controller states for the index renumbering block.
`timescale 1ns / 1ps

package fsir_pkg;

   // Field widths
   localparam int unsigned NODE_W  = 16;
   localparam int unsigned COUNT_W = 17;

   // Renumbering table size and address width
   localparam int unsigned TABLE_DEPTH = 65536;
   localparam int unsigned TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   // Run tag stored with every entry; tag zero marks a cleared entry
   localparam int unsigned        EPOCH_W   = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;

   // One table word: run tag and assigned compact number
   typedef struct packed {
      logic [EPOCH_W-1:0] epoch;
      logic [NODE_W-1:0]  number;
   } entry_type;

   // Controller states
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } state_type;

endpackage

// ===== rtl/first_seen_index_renumbering.sv =====
// Top level: first-seen index renumbering over a tagged renumbering table.
// Path: an accepted beat is registered in the lookup stage, then in the result registers.
// Throughput: one beat per cycle while busy is low; a beat's table read overlaps the prior write.
// A restart moves to a new run tag; the restart that finds the last tag (the 255th after reset,
// every 254th after that) holds busy high and waits through a clearing pass.
// Reset: synchronous; busy stays high through a clearing pass over all TABLE_DEPTH entries.
// The receiver cannot stall: each result is shown on the rsp_ ports for exactly one cycle.
`timescale 1ns / 1ps

module first_seen_index_renumbering
   import fsir_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [NODE_W-1:0]  req_node_index,
   input  logic               req_restart,
   input  logic               req_last_node,
   output logic               rsp_strobe,
   output logic [NODE_W-1:0]  rsp_compact_index,
   output logic               rsp_first_seen,
   output logic [NODE_W-1:0]  rsp_original_index,
   output logic [COUNT_W-1:0] rsp_distinct_count,
   output logic               rsp_run_done
);

   localparam logic [TABLE_AW-1:0] SWEEP_LAST = TABLE_AW'(TABLE_DEPTH - 1);

   // Table memory
   entry_type tbl_mem [TABLE_DEPTH];

   state_type state_ff, state_in;

   logic [TABLE_AW-1:0] sweep_ff, sweep_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [COUNT_W-1:0]  next_ff, next_in;

   // Lookup stage
   logic                s1_valid_ff, s1_valid_in;
   logic [NODE_W-1:0]   s1_index_ff;
   logic [TABLE_AW-1:0] s1_addr_ff;
   logic                s1_in_table_ff;
   logic                s1_restart_ff;
   logic                s1_last_ff;

   // Read data and forwarded write
   entry_type rd_ff;
   entry_type fwd_data_ff;
   logic      fwd_ff, fwd_in;

   // Result registers
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [NODE_W-1:0]  rsp_compact_ff;
   logic               rsp_first_ff;
   logic [NODE_W-1:0]  rsp_orig_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_done_ff;

   logic                accept;
   logic                wrap_stall;
   logic                clearing;
   logic                sweep_done;
   logic                s1_go;
   logic [TABLE_AW-1:0] req_addr;
   logic                req_in_table;
   entry_type           look;
   logic [EPOCH_W-1:0]  run_epoch;
   logic [COUNT_W-1:0]  base_count;
   logic                hit;
   logic                miss_write;
   logic                mem_we;
   logic [TABLE_AW-1:0] mem_waddr;
   entry_type           mem_wdata;
   logic [NODE_W-1:0]   compact;

   // Decode the request beat
   assign req_addr     = TABLE_AW'(req_node_index);
   assign req_in_table = 32'(req_node_index) < TABLE_DEPTH;

   // A restart at the last run tag waits for a clearing pass
   assign wrap_stall = s1_valid_ff && s1_restart_ff && (epoch_ff == EPOCH_MAX);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sweep_ff == SWEEP_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (wrap_stall) begin
               state_in = ST_CLEAR;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Controller outputs
   always_comb begin
      clearing   = 1'b0;
      sweep_done = 1'b0;
      busy       = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            clearing   = 1'b1;
            sweep_done = (sweep_ff == SWEEP_LAST);
            busy       = 1'b1;
         end
         ST_RUN: begin
            busy = wrap_stall;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign accept = start && !busy;
   assign s1_go  = s1_valid_ff && !busy;

   // Resolve the entry: forwarded write wins over the stale read
   assign look       = fwd_ff ? fwd_data_ff : rd_ff;
   assign run_epoch  = s1_restart_ff ? (epoch_ff + EPOCH_ONE) : epoch_ff;
   assign base_count = s1_restart_ff ? '0 : next_ff;
   assign hit        = s1_in_table_ff && !s1_restart_ff && (look.epoch == epoch_ff);
   assign miss_write = s1_go && s1_in_table_ff && !hit;

   always_comb begin
      compact = '0;
      if (hit) begin
         compact = look.number;
      end else if (s1_in_table_ff) begin
         compact = base_count[NODE_W-1:0];
      end
   end

   // Table write port: clearing pass or first-sight write
   always_comb begin
      mem_we           = 1'b0;
      mem_waddr        = s1_addr_ff;
      mem_wdata.epoch  = run_epoch;
      mem_wdata.number = base_count[NODE_W-1:0];
      if (clearing) begin
         mem_we           = 1'b1;
         mem_waddr        = sweep_ff;
         mem_wdata.epoch  = EPOCH_NONE;
         mem_wdata.number = '0;
      end else if (miss_write) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= tbl_mem[req_addr];
   end

   // Forward a write that lands on the address being read
   assign fwd_in = accept && miss_write && req_in_table && (req_addr == s1_addr_ff);

   always_ff @(posedge clock) begin
      fwd_data_ff <= mem_wdata;
   end

   // Counters, run tag and stage valid
   always_comb begin
      sweep_in = clearing ? (sweep_ff + TABLE_AW'(1)) : '0;
      epoch_in = epoch_ff;
      next_in  = next_ff;
      if (sweep_done) begin
         epoch_in = EPOCH_ONE;
      end else if (s1_go) begin
         epoch_in = run_epoch;
         next_in  = miss_write ? (base_count + COUNT_W'(1)) : base_count;
      end
      s1_valid_in   = accept || (s1_valid_ff && !s1_go);
      rsp_strobe_in = s1_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         epoch_ff      <= EPOCH_ONE;
         next_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         epoch_ff      <= epoch_in;
         next_ff       <= next_in;
         s1_valid_ff   <= s1_valid_in;
         fwd_ff        <= fwd_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Capture the accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_index_ff    <= req_node_index;
         s1_addr_ff     <= req_addr;
         s1_in_table_ff <= req_in_table;
         s1_restart_ff  <= req_restart;
         s1_last_ff     <= req_last_node;
      end
   end

   // Register the result beat
   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_compact_ff <= compact;
         rsp_first_ff   <= miss_write;
         rsp_orig_ff    <= s1_index_ff;
         rsp_count_ff   <= next_in;
         rsp_done_ff    <= s1_last_ff;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_compact_index  = rsp_compact_ff;
   assign rsp_first_seen     = rsp_first_ff;
   assign rsp_original_index = rsp_orig_ff;
   assign rsp_distinct_count = rsp_count_ff;
   assign rsp_run_done       = rsp_done_ff;

endmodule

// ===== rtl/fsir_checker.sv =====
// Port-level checks for the index renumbering block, bound to its top level.
`timescale 1ns / 1ps

module fsir_checker
   import fsir_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_restart,
   input logic               rsp_strobe,
   input logic [NODE_W-1:0]  rsp_compact_index,
   input logic               rsp_first_seen,
   input logic [COUNT_W-1:0] rsp_distinct_count
);

   // Reset starts a clearing pass
   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // A beat without restart never stalls in the lookup stage and always gives its result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_restart) |-> ##2 rsp_strobe)
      else $error("result of a plain beat missing");

   // A new number is the count before this beat
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_first_seen) |->
         (rsp_compact_index == NODE_W'(rsp_distinct_count - COUNT_W'(1))))
      else $error("new compact number does not match count");

   // A known nonzero number lies below the count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_first_seen && (rsp_compact_index != '0)) |->
         (COUNT_W'(rsp_compact_index) < rsp_distinct_count))
      else $error("known compact number beyond count");

endmodule

bind first_seen_index_renumbering fsir_checker u_fsir_checker (.*);

// ===== tb/sv/testbench.sv =====
// Testbench for first_seen_index_renumbering: directed table, random mesh runs, result checks.
`timescale 1ns / 1ps

module testbench;
   import fsir_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 8;
   localparam int POOL_MAX     = 32;

   // One result beat as the block reports it
   typedef struct {
      logic [NODE_W-1:0]  compact;
      logic               first;
      logic [NODE_W-1:0]  original;
      logic [COUNT_W-1:0] distinct;
      logic               done;
   } renumber_type;

   // One row of the directed table; typed rows carry their own expected result
   typedef struct {
      logic [NODE_W-1:0] node;
      logic              restart;
      logic              last;
      bit                typed;
      renumber_type      want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [NODE_W-1:0]  req_node_index;
   logic               req_restart;
   logic               req_last_node;
   logic               rsp_strobe;
   logic [NODE_W-1:0]  rsp_compact_index;
   logic               rsp_first_seen;
   logic [NODE_W-1:0]  rsp_original_index;
   logic [COUNT_W-1:0] rsp_distinct_count;
   logic               rsp_run_done;

   // Shadow renumbering table: an entry is assigned when its run id matches the current run
   int unsigned        entry_run [TABLE_DEPTH];
   logic [NODE_W-1:0]  entry_number [TABLE_DEPTH];
   int unsigned        current_run = 1;
   logic [COUNT_W-1:0] next_compact = '0;

   renumber_type  pending_renumbers [$];
   stim_row_type  directed_rows [$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            idle_pct = 0;

   first_seen_index_renumbering uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_node_index     (req_node_index),
      .req_restart        (req_restart),
      .req_last_node      (req_last_node),
      .rsp_strobe         (rsp_strobe),
      .rsp_compact_index  (rsp_compact_index),
      .rsp_first_seen     (rsp_first_seen),
      .rsp_original_index (rsp_original_index),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_run_done       (rsp_run_done)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Advance the shadow table by one node index and return its expected result
   function automatic renumber_type renumber_node(input logic [NODE_W-1:0] node,
                                                  input logic restart, input logic last);
      renumber_type r;
      if (restart) begin
         current_run++;
         next_compact = '0;
      end
      r.compact = '0;
      r.first   = 1'b0;
      if (int'(node) < TABLE_DEPTH) begin
         if (entry_run[node] == current_run) begin
            r.compact = entry_number[node];
         end else begin
            r.compact          = next_compact[NODE_W-1:0];
            entry_number[node] = next_compact[NODE_W-1:0];
            entry_run[node]    = current_run;
            next_compact       = next_compact + COUNT_W'(1);
            r.first            = 1'b1;
         end
      end
      r.original = node;
      r.distinct = next_compact;
      r.done     = last;
      return r;
   endfunction

   task automatic add_row(input logic [NODE_W-1:0] node, input logic restart,
                          input logic last, input bit typed,
                          input logic [NODE_W-1:0] compact, input logic first,
                          input logic [COUNT_W-1:0] distinct);
      stim_row_type row;
      row.node          = node;
      row.restart       = restart;
      row.last          = last;
      row.typed         = typed;
      row.want.compact  = compact;
      row.want.first    = first;
      row.want.original = node;
      row.want.distinct = distinct;
      row.want.done     = last;
      directed_rows.push_back(row);
   endtask

   // Offer one beat after a random idle gap, hold it until accepted, then log its result
   task automatic send_beat(input logic [NODE_W-1:0] node, input logic restart,
                            input logic last, input bit typed, input renumber_type want);
      renumber_type predicted;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_node_index <= node;
      req_restart    <= restart;
      req_last_node  <= last;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = renumber_node(node, restart, last);
      pending_renumbers.push_back(typed ? want : predicted);
   endtask

   task automatic check_field(input string field, input logic [COUNT_W-1:0] want,
                              input logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Compare every result beat with the oldest outstanding expectation
   always @(posedge clock) begin : result_check
      renumber_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_renumbers.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got original_index %0h",
                     $time, rsp_original_index);
            mismatch_count++;
         end else begin
            want = pending_renumbers.pop_front();
            check_field("compact_index", COUNT_W'(want.compact), COUNT_W'(rsp_compact_index));
            check_field("first_seen", COUNT_W'(want.first), COUNT_W'(rsp_first_seen));
            check_field("original_index", COUNT_W'(want.original),
                        COUNT_W'(rsp_original_index));
            check_field("distinct_count", want.distinct, rsp_distinct_count);
            check_field("run_done", COUNT_W'(want.done), COUNT_W'(rsp_run_done));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      renumber_type      no_want;
      logic [NODE_W-1:0] pool [POOL_MAX];
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] base;
      logic              rst;
      logic              lst;
      int                idle_levels [3];
      int                pool_size;
      int                run_len;
      int                beats;
      int                k;

      no_want        = '{default: '0};
      idle_levels    = '{0, 75, 26};
      reset          <= 1'b1;
      start          <= 1'b0;
      req_node_index <= '0;
      req_restart    <= 1'b0;
      req_last_node  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, back-to-back repeats, last node without restart, restart cases
      add_row(16'h0000, 1'b0, 1'b0, 1'b1, 16'd0, 1'b1, 17'd1);
      add_row(16'hFFFF, 1'b0, 1'b0, 1'b1, 16'd1, 1'b1, 17'd2);
      add_row(16'h0000, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0, 17'd2);
      add_row(16'hFFFF, 1'b0, 1'b1, 1'b1, 16'd1, 1'b0, 17'd2);
      add_row(16'h0000, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0, 17'd2);
      add_row(16'hFFFF, 1'b1, 1'b0, 1'b1, 16'd0, 1'b1, 17'd1);
      add_row(16'h0000, 1'b1, 1'b0, 1'b1, 16'd0, 1'b1, 17'd1);
      add_row(16'h0000, 1'b0, 1'b0, 1'b1, 16'd0, 1'b0, 17'd1);
      add_row(16'h5555, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'hAAAA, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h5555, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h1234, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h1234, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'hFFFF, 1'b0, 1'b1, 1'b0, '0, 1'b0, '0);
      add_row(16'hAAAA, 1'b1, 1'b1, 1'b0, '0, 1'b0, '0);
      add_row(16'h0001, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h8000, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h7FFF, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h0001, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h8000, 1'b1, 1'b0, 1'b0, '0, 1'b0, '0);
      add_row(16'h8000, 1'b0, 1'b1, 1'b0, '0, 1'b0, '0);
      foreach (directed_rows[i])
         send_beat(directed_rows[i].node, directed_rows[i].restart, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);

      // Random: one phase per idle level
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = idle_levels[phase];

         // Single-beat runs; enough restarts overall to wrap the run tag once
         repeat (90) begin
            node = NODE_W'($urandom_range(65535));
            lst  = 1'($urandom_range(1));
            send_beat(node, 1'b1, lst, 1'b0, no_want);
         end

         // Element lists drawn from a small pool so indices repeat, with some noise
         beats = 0;
         while (beats < 210) begin
            pool_size = $urandom_range(POOL_MAX, 1);
            base      = NODE_W'($urandom_range(65535));
            for (k = 0; k < pool_size; k++)
               pool[k] = ($urandom_range(3) == 0) ? NODE_W'($urandom_range(65535))
                                                  : base + NODE_W'($urandom_range(63));
            run_len = $urandom_range(48, 2);
            for (k = 0; k < run_len; k++) begin
               if ($urandom_range(9) == 0) begin
                  node = NODE_W'($urandom_range(65535));
                  rst  = ($urandom_range(15) == 0);
                  lst  = 1'($urandom_range(1));
               end else begin
                  node = pool[$urandom_range(pool_size - 1)];
                  rst  = (k == 0) && ($urandom_range(19) != 0);
                  lst  = (k == run_len - 1);
               end
               send_beat(node, rst, lst, 1'b0, no_want);
               beats++;
            end
         end
      end

      // Drain outstanding results, then let the pipeline settle
      start <= 1'b0;
      while (pending_renumbers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_renumbers.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/fsir_pkg.sv
rtl/first_seen_index_renumbering.sv
rtl/fsir_checker.sv
tb/sv/testbench.sv
